### rtl/assert_macros.svh
// Shared assertion macros for the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define HTSD_ASSERT(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define HTSD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define HTSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/htsd_pkg.sv
`default_nettype none

package htsd_pkg;

   localparam int NODE_SLOTS_DEFAULT = 512;
   localparam int BITS_PER_BYTE      = 8;
   localparam int TOP_BIT            = 7;
   localparam int BIT_W              = $clog2(BITS_PER_BYTE);
   localparam int COUNT_W            = 32;
   localparam int CMD_DEPTH          = 2;
   localparam int RSP_DEPTH          = 4;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_ERROR = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [BITS_PER_BYTE-1:0]  data;
   } cmd_type;

   typedef struct packed {
      logic [BITS_PER_BYTE-1:0]  symbol;
      logic                      run_end;
      logic                      block_end;
      logic                      malformed;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/htsd_ram.sv
`default_nettype none

module htsd_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 512,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/htsd_fifo.sv
`default_nettype none
`include "assert_macros.svh"

module htsd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full     = (count_ff == CNT_W'(DEPTH));
      empty    = (count_ff == '0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `HTSD_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH), "fifo count overrun")
   `HTSD_ASSERT_NEXT(a_push_fills, clock, reset, do_push && !do_pop, !empty, "fifo lost an entry")

endmodule

`default_nettype wire

### rtl/htsd_front.sv
`default_nettype none
`include "assert_macros.svh"

module htsd_front #(
   parameter int NODE_SLOTS = htsd_pkg::NODE_SLOTS_DEFAULT,
   localparam int LINK_W = $clog2(NODE_SLOTS),
   localparam int DATA_W = (LINK_W > htsd_pkg::BITS_PER_BYTE) ? LINK_W
                                                               : htsd_pkg::BITS_PER_BYTE,
   localparam int ENT_W  = DATA_W + 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [htsd_pkg::BITS_PER_BYTE-1:0]   data_byte,
   input  logic                                 first_byte,
   input  logic [htsd_pkg::COUNT_W-1:0]         symbol_count,
   output logic [htsd_pkg::COUNT_W-1:0]         block_count,
   output logic                                 cmd_push,
   output htsd_pkg::cmd_type                    cmd_data,
   input  logic                                 cmd_full,
   input  logic                                 cmd_empty,
   input  logic                                 back_busy,
   output logic                                 wr_en,
   output logic [LINK_W-1:0]                    wr_addr,
   output logic [ENT_W-1:0]                     wr_data
);

   import htsd_pkg::*;

   localparam int CNT_W = $clog2(NODE_SLOTS + 1);

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_TAG     = 5'b00010,
      PH_LETTER  = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_ERROR   = 5'b10000
   } phase_type;

   phase_type          phase_ff, phase_in, phase_cur;
   logic [CNT_W-1:0]   tag_ff, tag_in, tag_cur;
   logic [CNT_W-1:0]   free_ff, free_in, free_cur;
   logic [CNT_W:0]     free_plus2;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               accept, tag_over, store_over, root_leaf;

   always_comb begin
      // A block start rewrites the store: hold it until the walk has drained.
      full   = cmd_full || (first_byte && (!cmd_empty || back_busy));
      accept = push && !full;

      phase_cur  = first_byte ? PH_TAG : phase_ff;
      tag_cur    = first_byte ? '0 : tag_ff;
      free_cur   = first_byte ? CNT_W'(1) : free_ff;
      free_plus2 = {1'b0, free_cur} + (CNT_W + 1)'(2);
      tag_over   = (tag_cur >= CNT_W'(NODE_SLOTS));
      store_over = (free_plus2 > (CNT_W + 1)'(NODE_SLOTS));
      root_leaf  = (data_byte != '0) && (tag_cur == '0);

      phase_in      = phase_ff;
      tag_in        = tag_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      cmd_push      = 1'b0;
      cmd_data.kind = CMD_BYTE;
      cmd_data.data = data_byte;
      wr_en         = 1'b0;
      wr_addr       = tag_cur[LINK_W-1:0];
      wr_data       = {1'b0, DATA_W'(free_cur)};

      if (accept) begin
         if (first_byte) begin
            count_in = symbol_count;
         end
         case (phase_cur)
            PH_TAG: begin
               tag_in  = tag_cur;
               free_in = free_cur;
               if (tag_over || root_leaf || ((data_byte == '0) && store_over)) begin
                  cmd_push      = 1'b1;
                  cmd_data.kind = CMD_ERROR;
                  phase_in      = PH_ERROR;
               end else begin
                  cmd_push      = first_byte;
                  cmd_data.kind = CMD_START;
                  if (data_byte == '0) begin
                     // Internal node: its children take the next two free slots.
                     wr_en    = 1'b1;
                     free_in  = free_plus2[CNT_W-1:0];
                     tag_in   = tag_cur + 1'b1;
                     phase_in = (tag_in >= free_in) ? PH_PAYLOAD : PH_TAG;
                  end else begin
                     phase_in = PH_LETTER;
                  end
               end
            end
            PH_LETTER: begin
               wr_en    = !tag_over;
               wr_data  = {1'b1, DATA_W'(data_byte)};
               tag_in   = tag_cur + 1'b1;
               phase_in = (tag_in >= free_ff) ? PH_PAYLOAD : PH_TAG;
            end
            PH_PAYLOAD: begin
               cmd_push = 1'b1;
            end
            default: ;
         endcase
      end

      block_count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tag_ff   <= '0;
         free_ff  <= CNT_W'(1);
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         free_ff  <= free_in;
         count_ff <= count_in;
      end
   end

   `HTSD_ASSERT_IMPL(a_write_while_walk, clock, reset, wr_en, !back_busy, "store written during walk")

endmodule

`default_nettype wire

### rtl/htsd_back.sv
`default_nettype none
`include "assert_macros.svh"

module htsd_back #(
   parameter int NODE_SLOTS = htsd_pkg::NODE_SLOTS_DEFAULT,
   localparam int LINK_W = $clog2(NODE_SLOTS),
   localparam int DATA_W = (LINK_W > htsd_pkg::BITS_PER_BYTE) ? LINK_W
                                                               : htsd_pkg::BITS_PER_BYTE,
   localparam int ENT_W  = DATA_W + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_empty,
   output logic                          cmd_pop,
   input  htsd_pkg::cmd_type             cmd_data,
   input  logic [htsd_pkg::COUNT_W-1:0]  block_count,
   output logic [LINK_W-1:0]             rd_addr,
   input  logic [ENT_W-1:0]              rd_data,
   output logic                          rsp_push,
   output htsd_pkg::rsp_type             rsp_data,
   input  logic                          rsp_full,
   output logic                          busy
);

   import htsd_pkg::*;

   // The root is always internal and its first child sits in slot one.
   localparam logic [LINK_W-1:0] ROOT_LINK = LINK_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   logic [COUNT_W-1:0]       left_ff, left_in;
   logic [LINK_W-1:0]        link_ff, link_in, link_next;
   logic [LINK_W-1:0]        addr_ff, addr_in;
   logic [BITS_PER_BYTE-1:0] byte_ff, byte_in;
   logic [BIT_W-1:0]         bit_ff, bit_in, next_bit;
   logic                     pend_valid_ff, pend_valid_in;
   logic [BITS_PER_BYTE-1:0] pend_sym_ff, pend_sym_in;
   logic                     pend_blk_ff, pend_blk_in;
   logic                     leaf, stall, byte_done, flush_ok;

   function automatic logic [LINK_W-1:0] child_of(input logic [LINK_W-1:0] link,
                                                  input logic bit_val);
      logic [LINK_W:0] sum;
      sum = {1'b0, link} + {{LINK_W{1'b0}}, bit_val};
      return (sum >= (LINK_W + 1)'(NODE_SLOTS)) ? '0 : sum[LINK_W-1:0];
   endfunction

   always_comb begin
      state_in      = state_ff;
      left_in       = left_ff;
      link_in       = link_ff;
      addr_in       = addr_ff;
      byte_in       = byte_ff;
      bit_in        = bit_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_blk_in   = pend_blk_ff;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      rsp_data.symbol    = pend_sym_ff;
      rsp_data.run_end   = 1'b1;
      rsp_data.block_end = pend_blk_ff;
      rsp_data.malformed = 1'b0;

      leaf      = rd_data[ENT_W-1];
      next_bit  = bit_ff - 1'b1;
      stall     = 1'b0;
      byte_done = 1'b0;
      link_next = link_ff;
      flush_ok  = !pend_valid_ff || !rsp_full;

      case (state_ff)
         ST_IDLE: begin
            // Release the last letter of the previous byte.
            if (pend_valid_ff && !rsp_full) begin
               rsp_push      = 1'b1;
               pend_valid_in = 1'b0;
            end
            if (!cmd_empty) begin
               case (cmd_data.kind)
                  CMD_START: begin
                     if (flush_ok) begin
                        cmd_pop = 1'b1;
                        left_in = block_count;
                        link_in = ROOT_LINK;
                     end
                  end
                  CMD_ERROR: begin
                     if (!pend_valid_ff && !rsp_full) begin
                        cmd_pop            = 1'b1;
                        rsp_push           = 1'b1;
                        rsp_data.symbol    = '0;
                        rsp_data.run_end   = 1'b1;
                        rsp_data.block_end = 1'b0;
                        rsp_data.malformed = 1'b1;
                     end
                  end
                  CMD_BYTE: begin
                     if (flush_ok) begin
                        cmd_pop = 1'b1;
                        // Drop padding and trailing bytes once the block is complete.
                        if (left_ff != '0) begin
                           byte_in  = cmd_data.data;
                           bit_in   = BIT_W'(TOP_BIT);
                           addr_in  = child_of(link_ff, cmd_data.data[TOP_BIT]);
                           state_in = ST_WALK;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (leaf) begin
               stall = pend_valid_ff && rsp_full;
               if (!stall) begin
                  // A newer letter follows, so the held one is not the last of the byte.
                  rsp_push         = pend_valid_ff;
                  rsp_data.run_end = 1'b0;
                  pend_valid_in    = 1'b1;
                  pend_sym_in      = rd_data[BITS_PER_BYTE-1:0];
                  pend_blk_in      = (left_ff == COUNT_W'(1));
                  left_in          = left_ff - 1'b1;
               end
               link_next = ROOT_LINK;
               byte_done = (left_ff == COUNT_W'(1)) || (bit_ff == '0);
            end else begin
               link_next = rd_data[LINK_W-1:0];
               byte_done = (bit_ff == '0);
            end
            if (!stall) begin
               link_in = link_next;
               if (byte_done) begin
                  state_in = ST_IDLE;
               end else begin
                  bit_in  = next_bit;
                  addr_in = child_of(link_next, byte_ff[next_bit]);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_addr = addr_in;
      busy    = (state_ff == ST_WALK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         left_ff       <= '0;
         link_ff       <= ROOT_LINK;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         left_ff       <= left_in;
         link_ff       <= link_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      byte_ff     <= byte_in;
      bit_ff      <= bit_in;
      pend_sym_ff <= pend_sym_in;
      pend_blk_ff <= pend_blk_in;
   end

   `HTSD_ASSERT_IMPL(a_no_pop_in_walk, clock, reset, state_ff == ST_WALK, !cmd_pop, "command taken mid walk")
   `HTSD_ASSERT_IMPL(a_error_shape, clock, reset, rsp_push && rsp_data.malformed, (rsp_data.symbol == '0) && rsp_data.run_end && !rsp_data.block_end, "bad error transaction")

endmodule

`default_nettype wire

### rtl/huffman_tree_stream_decoder.sv
// Huffman tree stream decoder.
// Input channel: push/full, one compressed byte per transaction with
// req_first_byte marking the start of a block. Result channel: empty/pop,
// one decoded letter per transaction with run_end, block_end and malformed.
// Configuration: valid/ready with csr_symbol_count; ready is always high and
// the count is sampled by the byte that starts a block.
// A header byte gives no result. In the back end a payload byte is first
// taken from the command queue, then walked with one tree store read per
// bit, as the read-data to next-address loop of the store allows one step a
// cycle while no full result queue stalls the walk. The last letter of a
// byte is held until the byte ends.
// A block start waits in full until the walk of the previous block drains.
// A two-entry command queue parts the header parser from the walker, and a
// four-entry result queue parts the walker from the receiver: a stalled
// receiver stalls the walk, then the command queue, then the input.
// Reset (synchronous) empties both queues, returns to waiting for a block
// start and clears the symbol count; the tree store is not cleared.
`default_nettype none

module huffman_tree_stream_decoder #(
   parameter int NODE_SLOTS = htsd_pkg::NODE_SLOTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [htsd_pkg::BITS_PER_BYTE-1:0]  req_data_byte,
   input  logic                                req_first_byte,
   output logic                                empty,
   input  logic                                pop,
   output logic [htsd_pkg::BITS_PER_BYTE-1:0]  rsp_symbol,
   output logic                                rsp_run_end,
   output logic                                rsp_block_end,
   output logic                                rsp_malformed,
   input  logic                                valid,
   output logic                                ready,
   input  logic [htsd_pkg::COUNT_W-1:0]        csr_symbol_count
);

   import htsd_pkg::*;

   localparam int LINK_W = $clog2(NODE_SLOTS);
   localparam int DATA_W = (LINK_W > BITS_PER_BYTE) ? LINK_W : BITS_PER_BYTE;
   localparam int ENT_W  = DATA_W + 1;

   logic [COUNT_W-1:0] symbol_count_ff, symbol_count_in;
   logic [COUNT_W-1:0] block_count;
   logic               cmd_push, cmd_pop, cmd_full, cmd_empty;
   cmd_type            cmd_in_data, cmd_out_data;
   logic               rsp_push, rsp_full;
   rsp_type            rsp_in_data, rsp_out_data;
   logic               back_busy;
   logic               wr_en;
   logic [LINK_W-1:0]  wr_addr, rd_addr;
   logic [ENT_W-1:0]   wr_data, rd_data;

   always_comb begin
      ready           = 1'b1;
      symbol_count_in = (valid && ready) ? csr_symbol_count : symbol_count_ff;
      rsp_symbol      = rsp_out_data.symbol;
      rsp_run_end     = rsp_out_data.run_end;
      rsp_block_end   = rsp_out_data.block_end;
      rsp_malformed   = rsp_out_data.malformed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= '0;
      end else begin
         symbol_count_ff <= symbol_count_in;
      end
   end

   htsd_front #(
      .NODE_SLOTS (NODE_SLOTS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .data_byte    (req_data_byte),
      .first_byte   (req_first_byte),
      .symbol_count (symbol_count_ff),
      .block_count  (block_count),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_in_data),
      .cmd_full     (cmd_full),
      .cmd_empty    (cmd_empty),
      .back_busy    (back_busy),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   htsd_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   htsd_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NODE_SLOTS)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   htsd_back #(
      .NODE_SLOTS (NODE_SLOTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (cmd_empty),
      .cmd_pop     (cmd_pop),
      .cmd_data    (cmd_out_data),
      .block_count (block_count),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_push    (rsp_push),
      .rsp_data    (rsp_in_data),
      .rsp_full    (rsp_full),
      .busy        (back_busy)
   );

   htsd_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_data),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_out_data),
      .empty     (empty)
   );

endmodule

`default_nettype wire
